[sv/tsvp_pkg.sv]
// ----------------------------------------------------------------------------
// tsvp_pkg
// Types, character constants and helpers shared by the search vector text
// parser: input and result words, the paired queue entry, parser phases.
// ----------------------------------------------------------------------------
package tsvp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [13:0] POS_LIMIT   = 14'd16383;
  localparam logic [1:0]  WEIGHT_D    = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_WEND   = 3'd1,
    KIND_POS    = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_WORD   = 3'd1,
    PH_QUOTE  = 3'd2,
    PH_LIST   = 3'd3,
    PH_DIGITS = 3'd4,
    PH_WEIGHT = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  word_char;
    logic [13:0] position_value;
    logic [1:0]  weight_code;
    logic        end_of_run;
  } out_word_t;

  // One queue entry: the results of one byte, one or two of them.
  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } pair_t;

  typedef struct packed {
    phase_t phase;
    logic   drop_rest;
  } front_stat_t;

  typedef struct packed {
    logic valid;
    logic idx;
    logic two;
  } back_stat_t;

  function automatic out_word_t make_word(kind_t k, logic [7:0] ch,
                                          logic [13:0] pos, logic [1:0] w);
    out_word_t r;
    r.kind           = k;
    r.word_char      = ch;
    r.position_value = pos;
    r.weight_code    = w;
    r.end_of_run     = (k == KIND_ACCEPT) || (k == KIND_ERROR);
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[sv/text_search_vector_text_parser.sv]
// ----------------------------------------------------------------------------
// text_search_vector_text_parser
// Streaming parser for the text form of a search vector: quoted words with
// optional position lists, one byte per word in, parse events out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake       | word        | notes
//  ---------+-----------------+-------------+------------------------------
//  input    | push / full     | in_data     | one text byte plus last flag
//  result   | empty / pop     | out_data    | byte, word end, position,
//           |                 |             | accept or error
//
// Cycles: the parser takes one byte per clock while full is low; a byte's
// results pass through the pair queue and the output register. A byte
// gives zero, one or two results, and each result takes one pop, so a
// byte with two results holds the drain for two pops. The pair queue
// (QUEUE_DEPTH entries) sets how far the parser runs ahead of the drain.
// Reset: synchronous; clears parse state, queue and output register.
// Stalls: full rises only when the queue is full; pop may idle freely.
// ----------------------------------------------------------------------------
module text_search_vector_text_parser #(
  parameter int QUEUE_DEPTH = tsvp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tsvp_pkg::in_word_t   in_data,
  output logic                 empty,
  input  logic                 pop,
  output tsvp_pkg::out_word_t  out_data
);
  import tsvp_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic          accept;
  logic          q_push;
  pair_t         q_wdata;
  pair_t         q_rdata;
  logic          q_nonempty;
  logic          q_rd;
  logic [CW-1:0] q_count;
  front_stat_t   f_stat;
  back_stat_t    b_stat;

  // take a byte whenever the queue has room
  assign accept = push && !full;

  // Front: classify the byte and produce its results.
  tsvp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .stat    (f_stat)
  );

  // Queue: decouple parsing from draining.
  tsvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (full),
    .rd_en    (q_rd),
    .rd_data  (q_rdata),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  // Back: hand results out one word at a time.
  tsvp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_nonempty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop),
    .stat     (b_stat)
  );

  // A final byte always leaves the parser ready for a fresh string.
  a_reset_after_final: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.final_byte) |=>
      (f_stat.phase == PH_SPACE && !f_stat.drop_rest))
    else $error("parser not back to start after final byte");

  // Dropping begins only on a byte that is not the last one.
  a_drop_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(f_stat.drop_rest) |-> $past(accept && !in_data.final_byte))
    else $error("drop mode entered without a non-final byte");

  // The second result is shown only for an entry that carries two.
  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    b_stat.idx |-> (b_stat.valid && b_stat.two))
    else $error("second result shown for a single-result entry");

  // Queued results reach the empty output register in the next cycle.
  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    (empty && (q_count != '0)) |=> !empty)
    else $error("output register left empty while queue holds results");

endmodule

[sv/tsvp_front.sv]
// ----------------------------------------------------------------------------
// tsvp_front
// Byte parser: classifies each accepted byte against the current phase,
// updates the parse state and hands the byte's results to the queue.
// ----------------------------------------------------------------------------
module tsvp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  tsvp_pkg::in_word_t   in_data,
  output logic                 q_push,
  output tsvp_pkg::pair_t      q_data,
  output tsvp_pkg::front_stat_t stat
);
  import tsvp_pkg::*;

  phase_t      phase, phase_next;
  logic        word_nonempty, word_nonempty_next;
  logic [13:0] position_accum, position_accum_next;
  logic        position_overflow, position_overflow_next;
  logic        drop_rest, drop_rest_next;

  logic [7:0]  c;
  logic        last;
  logic [3:0]  digit;
  logic [17:0] scaled;
  logic [1:0]  letter_w;
  logic        close_bad;
  out_word_t   close_word;
  out_word_t   err_word;

  // after-lexeme outcome for the current byte
  phase_t      al_phase;
  logic        al_wn;
  logic        al_fail;

  // take-byte outcome
  phase_t      tk_phase;
  logic        tk_wn;
  logic [13:0] tk_acc;
  logic        tk_ovf;
  logic        tk_fail;
  logic [1:0]  tk_n;
  out_word_t   tk_r0, tk_r1;

  // end-of-string outcome
  logic        do_fin;
  logic [1:0]  fn;
  out_word_t   fr0, fr1;
  logic        fin_bad;

  logic [1:0]  total_n;

  assign c        = in_data.text_byte;
  assign last     = in_data.final_byte;
  assign digit    = c[3:0];
  assign scaled   = {1'b0, position_accum, 3'b000} + {3'b000, position_accum, 1'b0}
                  + {14'd0, digit};
  assign letter_w = 2'(c - CH_A);
  assign close_bad = (position_accum == 14'd0) || position_overflow;
  assign err_word  = make_word(KIND_ERROR, 8'd0, 14'd0, 2'd0);

  always_comb begin
    al_wn   = word_nonempty;
    al_fail = 1'b0;
    al_phase = phase;
    if (is_space(c)) begin
      al_phase = PH_SPACE;
    end else if (c == CH_QUOTE) begin
      al_phase = PH_WORD;
      al_wn    = 1'b0;
    end else begin
      al_fail  = 1'b1;
    end
  end

  // Take one byte.
  always_comb begin
    tk_phase = phase;
    tk_wn    = word_nonempty;
    tk_acc   = position_accum;
    tk_ovf   = position_overflow;
    tk_fail  = 1'b0;
    tk_n     = 2'd0;
    tk_r0    = err_word;
    tk_r1    = err_word;
    close_word = close_bad ? err_word : make_word(KIND_POS, 8'd0, position_accum, WEIGHT_D);
    unique case (phase)
      PH_WORD: begin
        if (c == CH_QUOTE) begin
          tk_phase = PH_QUOTE;
        end else begin
          tk_r0 = make_word(KIND_BYTE, c, 14'd0, 2'd0);
          tk_n  = 2'd1;
          tk_wn = 1'b1;
        end
      end
      PH_QUOTE: begin
        tk_n = 2'd1;
        if (c == CH_QUOTE) begin
          tk_r0    = make_word(KIND_BYTE, c, 14'd0, 2'd0);
          tk_wn    = 1'b1;
          tk_phase = PH_WORD;
        end else if (!word_nonempty) begin
          tk_fail = 1'b1;
        end else begin
          tk_r0 = make_word(KIND_WEND, 8'd0, 14'd0, 2'd0);
          if (c == CH_COLON) begin
            tk_phase = PH_LIST;
          end else begin
            tk_phase = al_phase;
            tk_wn    = al_wn;
            if (al_fail) begin
              tk_fail = 1'b1;
              tk_n    = 2'd2;
            end
          end
        end
      end
      PH_LIST, PH_WEIGHT: begin
        if ((phase == PH_WEIGHT) && (c == CH_COMMA)) begin
          tk_phase = PH_LIST;
        end else if (is_digit(c)) begin
          tk_acc   = {10'd0, digit};
          tk_ovf   = 1'b0;
          tk_phase = PH_DIGITS;
        end else if (c == CH_COMMA) begin
          tk_fail = 1'b1;
          tk_n    = 2'd1;
        end else begin
          tk_phase = al_phase;
          tk_wn    = al_wn;
          if (al_fail) begin
            tk_fail = 1'b1;
            tk_n    = 2'd1;
          end
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          // saturate and stick on overflow
          if (scaled > {4'd0, POS_LIMIT}) begin
            tk_acc = POS_LIMIT;
            tk_ovf = 1'b1;
          end else begin
            tk_acc = scaled[13:0];
          end
        end else begin
          tk_n    = 2'd1;
          tk_fail = close_bad;
          if ((c >= CH_A) && (c <= CH_D)) begin
            tk_r0    = close_bad ? err_word
                                 : make_word(KIND_POS, 8'd0, position_accum, letter_w);
            tk_phase = PH_WEIGHT;
          end else if (c == CH_COMMA) begin
            tk_r0    = close_word;
            tk_phase = PH_LIST;
          end else begin
            tk_r0 = close_word;
            if (!close_bad) begin
              tk_phase = al_phase;
              tk_wn    = al_wn;
              if (al_fail) begin
                tk_fail = 1'b1;
                tk_n    = 2'd2;
              end
            end
          end
        end
      end
      default: begin
        tk_phase = al_phase;
        tk_wn    = al_wn;
        if (al_fail) begin
          tk_fail = 1'b1;
          tk_n    = 2'd1;
        end
      end
    endcase
  end

  // Close the string on the final byte.
  assign do_fin  = last && !tk_fail;
  assign fin_bad = (tk_acc == 14'd0) || tk_ovf;

  always_comb begin
    fn  = 2'd1;
    fr0 = err_word;
    fr1 = make_word(KIND_ACCEPT, 8'd0, 14'd0, 2'd0);
    unique case (tk_phase)
      PH_WORD: begin
        fn = 2'd1;
      end
      PH_QUOTE: begin
        if (tk_wn) begin
          fr0 = make_word(KIND_WEND, 8'd0, 14'd0, 2'd0);
          fn  = 2'd2;
        end
      end
      PH_DIGITS: begin
        if (!fin_bad) begin
          fr0 = make_word(KIND_POS, 8'd0, tk_acc, WEIGHT_D);
          fn  = 2'd2;
        end
      end
      default: begin
        fr0 = make_word(KIND_ACCEPT, 8'd0, 14'd0, 2'd0);
        fn  = 2'd1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next             = phase;
    word_nonempty_next     = word_nonempty;
    position_accum_next    = position_accum;
    position_overflow_next = position_overflow;
    drop_rest_next         = drop_rest;
    if (accept) begin
      if (last) begin
        phase_next             = PH_SPACE;
        word_nonempty_next     = 1'b0;
        position_accum_next    = 14'd0;
        position_overflow_next = 1'b0;
        drop_rest_next         = 1'b0;
      end else if (!drop_rest) begin
        phase_next             = tk_phase;
        word_nonempty_next     = tk_wn;
        position_accum_next    = tk_acc;
        position_overflow_next = tk_ovf;
        drop_rest_next         = tk_fail;
      end
    end
  end

  // Outputs: pack up to two results, take results first.
  always_comb begin
    total_n       = 2'd0;
    q_data.first  = tk_r0;
    q_data.second = tk_r1;
    case (tk_n)
      2'd0: begin
        q_data.first  = fr0;
        q_data.second = fr1;
        total_n       = do_fin ? fn : 2'd0;
      end
      2'd1: begin
        q_data.second = fr0;
        total_n       = do_fin ? 2'd2 : 2'd1;
      end
      default: begin
        total_n = 2'd2;
      end
    endcase
    q_data.two = (total_n == 2'd2);
    q_push     = accept && !drop_rest && (total_n != 2'd0);
  end

  assign stat.phase     = phase;
  assign stat.drop_rest = drop_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SPACE;
      word_nonempty     <= 1'b0;
      position_accum    <= 14'd0;
      position_overflow <= 1'b0;
      drop_rest         <= 1'b0;
    end else begin
      phase             <= phase_next;
      word_nonempty     <= word_nonempty_next;
      position_accum    <= position_accum_next;
      position_overflow <= position_overflow_next;
      drop_rest         <= drop_rest_next;
    end
  end

endmodule

[sv/tsvp_queue.sv]
// ----------------------------------------------------------------------------
// tsvp_queue
// Short first-in first-out queue of result pairs between parser and drain.
// ----------------------------------------------------------------------------
module tsvp_queue #(
  parameter int DEPTH = tsvp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  tsvp_pkg::pair_t               wr_data,
  output logic                          full,
  input  logic                          rd_en,
  output tsvp_pkg::pair_t               rd_data,
  output logic                          nonempty,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import tsvp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  pair_t           slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_wr, do_rd;

  assign full     = (fill == CW'(DEPTH));
  assign nonempty = (fill != '0);
  assign count    = fill;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[sv/tsvp_back.sv]
// ----------------------------------------------------------------------------
// tsvp_back
// Result drain: holds one queue entry in an output register and presents
// its results one word at a time.
// ----------------------------------------------------------------------------
module tsvp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  tsvp_pkg::pair_t       q_data,
  output logic                  q_rd,
  output tsvp_pkg::out_word_t   out_data,
  output logic                  empty,
  input  logic                  pop,
  output tsvp_pkg::back_stat_t  stat
);
  import tsvp_pkg::*;

  pair_t hold;
  logic  hold_valid;
  logic  idx;
  logic  taken;
  logic  done;

  assign taken = hold_valid && pop;
  assign done  = taken && (!hold.two || idx);
  assign q_rd  = q_valid && (!hold_valid || done);

  assign empty    = !hold_valid;
  assign out_data = idx ? hold.second : hold.first;

  assign stat.valid = hold_valid;
  assign stat.idx   = idx;
  assign stat.two   = hold.two;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      hold <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 1'b0;
    end else if (q_rd) begin
      hold_valid <= 1'b1;
      idx        <= 1'b0;
    end else if (done) begin
      hold_valid <= 1'b0;
      idx        <= 1'b0;
    end else if (taken) begin
      // advance to the second result of the entry
      idx <= 1'b1;
    end
  end

endmodule

[bench/tb_text_search_vector_text_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_search_vector_text_parser
// Self-checking bench for the search vector text parser. A short table of
// directed strings comes first, then random strings, mostly well-formed
// lexeme lists with random words and positions, some broken, some pure noise.
// Each accepted byte runs through a bench-side parser model. Every popped
// word is compared field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_text_search_vector_text_parser;
  import tsvp_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 20;
  localparam int SHOWN_ERRORS  = 10;
  localparam int MAX_PER_BYTE  = 2;
  localparam int unsigned RADIX = 10;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam out_word_t  NO_WORD    = '0;

  // One row of the directed table. With n_typed at -1 the row is checked
  // against the model; otherwise the row carries its own expected words.
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    int         n_typed;
    out_word_t  exp0;
    out_word_t  exp1;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  in_data;
  logic      empty;
  logic      pop;
  out_word_t out_data;

  text_search_vector_text_parser dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bench-side parser state.
  phase_t      ps_phase;
  logic        ps_nonempty;
  int unsigned ps_accum;
  logic        ps_overflow;
  logic        ps_drop;

  // Words caused by the byte under prediction, and the error flag of that byte.
  out_word_t   step_out[$];
  logic        step_err;

  // Predicted words still waiting to be popped, oldest first.
  out_word_t   expected_q[$];

  stim_row_t   dir_rows[$];
  logic [7:0]  text_q[$];

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          live_items     = 0;
  int          send_idle_pct  = 27;
  int          recv_idle_pct  = 79;
  logic        hold_req       = 1'b0;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  function automatic logic ws_char(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic out_word_t pack_result(kind_t k, logic [7:0] ch,
                                            logic [13:0] pos, logic [1:0] w);
    out_word_t r;
    r.kind           = k;
    r.word_char      = ch;
    r.position_value = pos;
    r.weight_code    = w;
    r.end_of_run     = (k == KIND_ACCEPT) || (k == KIND_ERROR);
    return r;
  endfunction

  task automatic clear_parser();
    ps_phase    = PH_SPACE;
    ps_nonempty = 1'b0;
    ps_accum    = 0;
    ps_overflow = 1'b0;
    ps_drop     = 1'b0;
  endtask

  // Drop anything past two words; a byte never yields more.
  task automatic emit_result(kind_t k, logic [7:0] ch, logic [13:0] pos,
                             logic [1:0] w);
    if (step_out.size() < MAX_PER_BYTE) step_out = {step_out, pack_result(k, ch, pos, w)};
  endtask

  // Only the first error of a byte gives a word.
  task automatic raise_error();
    if (!step_err) emit_result(KIND_ERROR, 8'h00, 14'd0, 2'd0);
    step_err = 1'b1;
  endtask

  task automatic close_position(logic [1:0] w);
    if ((ps_accum == 0) || ps_overflow) begin
      raise_error();
    end else begin
      emit_result(KIND_POS, 8'h00, ps_accum[13:0], w);
    end
  endtask

  // A byte where whitespace or the next opening quote may stand.
  task automatic after_lexeme(logic [7:0] c);
    if (ws_char(c)) begin
      ps_phase = PH_SPACE;
    end else if (c == CH_QUOTE) begin
      ps_phase    = PH_WORD;
      ps_nonempty = 1'b0;
    end else begin
      raise_error();
    end
  endtask

  // A byte where a new position number may start.
  task automatic list_char(logic [7:0] c);
    if (digit_char(c)) begin
      ps_accum    = 32'(c - CH_ZERO);
      ps_overflow = 1'b0;
      ps_phase    = PH_DIGITS;
    end else if (c == CH_COMMA) begin
      raise_error();
    end else begin
      after_lexeme(c);
    end
  endtask

  // Advance the model by one accepted byte; leave its words in step_out.
  task automatic parse_byte(in_word_t w);
    logic [7:0]  c;
    int unsigned v;
    c = w.text_byte;
    step_out.delete();
    step_err = 1'b0;
    if (ps_drop) begin
      // After an error, swallow bytes up to the end of the string.
      if (w.final_byte) clear_parser();
    end else begin
      case (ps_phase)
        PH_WORD: begin
          if (c == CH_QUOTE) begin
            ps_phase = PH_QUOTE;
          end else begin
            emit_result(KIND_BYTE, c, 14'd0, 2'd0);
            ps_nonempty = 1'b1;
          end
        end
        PH_QUOTE: begin
          if (c == CH_QUOTE) begin
            // Doubled quote: one literal quote inside the word.
            emit_result(KIND_BYTE, c, 14'd0, 2'd0);
            ps_nonempty = 1'b1;
            ps_phase    = PH_WORD;
          end else if (!ps_nonempty) begin
            raise_error();
          end else begin
            emit_result(KIND_WEND, 8'h00, 14'd0, 2'd0);
            if (c == CH_COLON) ps_phase = PH_LIST;
            else after_lexeme(c);
          end
        end
        PH_LIST: list_char(c);
        PH_DIGITS: begin
          if (digit_char(c)) begin
            // Saturate and remember the overflow instead of wrapping.
            v = ps_accum * RADIX + 32'(c - CH_ZERO);
            if (v > 32'(POS_LIMIT)) begin
              ps_overflow = 1'b1;
              v = 32'(POS_LIMIT);
            end
            ps_accum = v;
          end else if ((c >= CH_A) && (c <= CH_D)) begin
            close_position(2'(c - CH_A));
            ps_phase = PH_WEIGHT;
          end else if (c == CH_COMMA) begin
            close_position(WEIGHT_D);
            ps_phase = PH_LIST;
          end else begin
            close_position(WEIGHT_D);
            if (!step_err) after_lexeme(c);
          end
        end
        PH_WEIGHT: begin
          if (c == CH_COMMA) ps_phase = PH_LIST;
          else list_char(c);
        end
        default: after_lexeme(c);
      endcase

      // Close the string on its last byte.
      if (!step_err && w.final_byte) begin
        case (ps_phase)
          PH_WORD: raise_error();
          PH_QUOTE: begin
            if (!ps_nonempty) begin
              raise_error();
            end else begin
              emit_result(KIND_WEND, 8'h00, 14'd0, 2'd0);
              emit_result(KIND_ACCEPT, 8'h00, 14'd0, 2'd0);
            end
          end
          PH_DIGITS: begin
            close_position(WEIGHT_D);
            if (!step_err) emit_result(KIND_ACCEPT, 8'h00, 14'd0, 2'd0);
          end
          default: emit_result(KIND_ACCEPT, 8'h00, 14'd0, 2'd0);
        endcase
      end

      if (w.final_byte) clear_parser();
      else if (step_err) ps_drop = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_row(logic [7:0] ch, logic fin, int n_typed,
                         out_word_t exp0, out_word_t exp1);
    stim_row_t r;
    r.ch      = ch;
    r.fin     = fin;
    r.n_typed = n_typed;
    r.exp0    = exp0;
    r.exp1    = exp1;
    dir_rows  = {dir_rows, r};
  endtask

  // Rows checked against the model; fin marks the last character.
  task automatic add_text(string s, logic fin);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_row(s[i], fin && (i == s.len() - 1), -1, NO_WORD, NO_WORD);
    end
  endtask

  // Append one byte to the string under construction.
  task automatic put_char(logic [7:0] c);
    text_q = {text_q, c};
  endtask

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 1) != 0) return CH_SPACE;
    return 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  // Bytes biased toward the ones the parser cares about.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0:       return CH_QUOTE;
      1:       return CH_COLON;
      2:       return CH_COMMA;
      3:       return 8'(CH_ZERO + $urandom_range(0, 9));
      4:       return 8'(CH_A + $urandom_range(0, 3));
      5:       return blank_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_word_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: begin
        // doubled quote
        put_char(CH_QUOTE);
        put_char(CH_QUOTE);
      end
      1, 2: begin
        c = 8'($urandom_range(0, 255));
        put_char((c == CH_QUOTE) ? CH_LOWER_A : c);
      end
      default: put_char(8'(CH_LOWER_A + $urandom_range(0, 25)));
    endcase
  endtask

  // Position number: mostly legal, sometimes zero, the limit or beyond it.
  task automatic add_number();
    int unsigned n;
    string       digits;
    int          i;
    case ($urandom_range(0, 11))
      0:       n = 0;
      1:       n = $urandom_range(16384, 99999);
      2:       n = 32'(POS_LIMIT);
      3:       n = $urandom_range(1, 16383);
      default: n = $urandom_range(1, 200);
    endcase
    if ($urandom_range(0, 7) == 0) put_char(CH_ZERO);
    digits = $sformatf("%0d", n);
    for (i = 0; i < digits.len(); i++) put_char(digits[i]);
    if ($urandom_range(0, 1) != 0) put_char(8'(CH_A + $urandom_range(0, 3)));
  endtask

  // Fill text_q with one random string.
  task automatic build_string();
    int n_lex;
    int n_pos;
    int l;
    int p;
    int keep;
    text_q.delete();
    case ($urandom_range(0, 19))
      0: begin
        repeat ($urandom_range(1, 3)) put_char(blank_char());
      end
      1, 2, 3: begin
        repeat ($urandom_range(1, 8)) put_char(noise_char());
      end
      default: begin
        repeat ($urandom_range(0, 2)) put_char(blank_char());
        n_lex = $urandom_range(1, 3);
        for (l = 0; l < n_lex; l++) begin
          // Lexemes may also sit back to back with no blank between them.
          if ((l > 0) && ($urandom_range(0, 3) != 0)) put_char(blank_char());
          put_char(CH_QUOTE);
          if ($urandom_range(0, 15) != 0) begin
            repeat ($urandom_range(1, 4)) add_word_char();
          end
          put_char(CH_QUOTE);
          if ($urandom_range(0, 1) != 0) begin
            put_char(CH_COLON);
            n_pos = $urandom_range(0, 3);
            for (p = 0; p < n_pos; p++) begin
              if (p > 0) put_char(CH_COMMA);
              // Now and then leave the number out: comma with no digits.
              if ($urandom_range(0, 19) != 0) add_number();
            end
            if ($urandom_range(0, 9) == 0) put_char(CH_COMMA);
          end
        end
        if ($urandom_range(0, 3) == 0) put_char(blank_char());
        // Break a few: overwrite one byte, or cut the tail off.
        if ($urandom_range(0, 9) == 0) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (($urandom_range(0, 14) == 0) && (text_q.size() > 1)) begin
          keep   = $urandom_range(1, text_q.size() - 1);
          text_q = text_q[0:keep-1];
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side: present a word at the falling edge, hold it until accepted.
  // --------------------------------------------------------------------------

  task automatic send_word(in_word_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
  endtask

  // Lower push and hold until every predicted word has been popped.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: pop at random, or hold off for a long stretch on request.
  // --------------------------------------------------------------------------

  initial begin : drain_side
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each popped word with the oldest prediction.
  always @(posedge clk) begin : check_word
    out_word_t want;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word kind=%0d char=%02h pos=%0d w=%0d end=%0b",
                                out_data.kind, out_data.word_char, out_data.position_value,
                                out_data.weight_code, out_data.end_of_run));
      end else begin
        want = expected_q.pop_front();
        if ((out_data.kind !== want.kind) ||
            (out_data.word_char !== want.word_char) ||
            (out_data.position_value !== want.position_value) ||
            (out_data.weight_code !== want.weight_code) ||
            (out_data.end_of_run !== want.end_of_run)) begin
          note_mismatch($sformatf({"got kind=%0d char=%02h pos=%0d w=%0d end=%0b, ",
                                   "expected kind=%0d char=%02h pos=%0d w=%0d end=%0b"},
                                  out_data.kind, out_data.word_char,
                                  out_data.position_value, out_data.weight_code,
                                  out_data.end_of_run, want.kind, want.word_char,
                                  want.position_value, want.weight_code, want.end_of_run));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    in_word_t w;
    int       i;
    rst     = 1'b1;
    push    = 1'b0;
    in_data = '0;
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Expected words are typed in where they are obvious.
    // Blank string straight out of reset: accepted.
    add_row(CH_SPACE, 1'b1, 1, pack_result(KIND_ACCEPT, 8'h00, 14'd0, 2'd0), NO_WORD);
    // Word made of the two extreme byte values, closed by the last byte.
    add_row(CH_QUOTE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'h00, 1'b0, 1, pack_result(KIND_BYTE, 8'h00, 14'd0, 2'd0), NO_WORD);
    add_row(8'hFF, 1'b0, 1, pack_result(KIND_BYTE, 8'hFF, 14'd0, 2'd0), NO_WORD);
    add_row(CH_QUOTE, 1'b1, 2, pack_result(KIND_WEND, 8'h00, 14'd0, 2'd0),
            pack_result(KIND_ACCEPT, 8'h00, 14'd0, 2'd0));
    // Empty word: error, then the rest of the string is swallowed.
    add_row(CH_QUOTE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CH_QUOTE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CH_LOWER_A + 8'd23, 1'b0, 1, pack_result(KIND_ERROR, 8'h00, 14'd0, 2'd0),
            NO_WORD);
    add_row(CH_LOWER_A + 8'd24, 1'b1, 0, NO_WORD, NO_WORD);
    // Doubled quote, then the largest legal position with weight A and a
    // default-weight position closed by the last byte.
    add_text("'q''':1638", 1'b0);
    add_row(CH_ZERO + 8'd3, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CH_A, 1'b0, 1, pack_result(KIND_POS, 8'h00, POS_LIMIT, 2'd0), NO_WORD);
    add_text(",1", 1'b1);
    // Unterminated quote.
    add_text("'z", 1'b1);

    foreach (dir_rows[r]) begin
      w.text_byte  = dir_rows[r].ch;
      w.final_byte = dir_rows[r].fin;
      send_word(w);
      parse_byte(w);
      if (dir_rows[r].n_typed < 0) begin
        foreach (step_out[k]) expected_q = {expected_q, step_out[k]};
      end else begin
        if (dir_rows[r].n_typed > 0) expected_q = {expected_q, dir_rows[r].exp0};
        if (dir_rows[r].n_typed > 1) expected_q = {expected_q, dir_rows[r].exp1};
      end
    end

    // Pause the input until the output side has caught up.
    wait_drained();

    // Starve the output for a while so the queue fills and full rises.
    hold_req = 1'b1;

    while (live_items < RANDOM_ITEMS) begin
      // Idle mix: slow drain first, then slow feed, then full speed.
      if (live_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 79;
      end else if (live_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      build_string();
      for (i = 0; i < text_q.size(); i++) begin
        w.text_byte  = text_q[i];
        w.final_byte = (i == text_q.size() - 1);
        send_word(w);
        live_items++;
        parse_byte(w);
        foreach (step_out[k]) expected_q = {expected_q, step_out[k]};
      end
    end

    wait_drained();
    // Catch any stray word after the last prediction.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
